// ===== src/hcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared constants of the Huffman compressed-size meter.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int BYTE_W   = 8;   // width of one text byte
    localparam int OUT_W    = 14;  // width of the size results
    localparam int BIT_SHFT = 3;   // bits per byte as a shift (x8)

    // scan candidate count saturates at two
    localparam logic [1:0] CAND_NONE = 2'd0;
    localparam logic [1:0] CAND_ONE  = 2'd1;
    localparam logic [1:0] CAND_TWO  = 2'd2;

endpackage
// ----------------------------------------------------------------------------

// ===== src/hcs_hist.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcs_hist
// Count / node-weight memory with per-entry valid bits; an invalid entry
// reads as zero. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hcs_hist #(
    parameter int ALPHABET = 256,
    parameter int CW       = 11
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [$clog2(ALPHABET)-1:0]  i_rd_addr,
    output logic [CW-1:0]                o_rd_data,
    input  wire                          i_wr_en,
    input  wire  [$clog2(ALPHABET)-1:0]  i_wr_addr,
    input  wire  [CW-1:0]                i_wr_data,
    input  wire                          i_kill_en,
    input  wire  [$clog2(ALPHABET)-1:0]  i_kill_addr,
    input  wire                          i_clr_all
);

    logic [CW-1:0]       r_mem [ALPHABET];
    logic [ALPHABET-1:0] r_vld;
    logic [CW-1:0]       r_rd_data;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr_all) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_kill_en) begin
                r_vld[i_kill_addr] <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

// ===== src/huffman_compressed_size.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_compressed_size
// Byte histogram plus iterative Huffman merge; reports original and
// compressed size in bits.
// ----------------------------------------------------------------------------
// A counted byte keeps busy high through a read, then a write of the count
// memory; a byte dropped for length or range skips both. A last byte adds
// the tree build: D scans of the whole memory, each followed by a merge step,
// D = distinct symbols (at least one scan), then a done state; the result
// strobe follows in the next cycle, as busy drops. The single count-memory
// read port paces the scans. Receiver cannot stall the one-cycle strobe.
// Reset (synchronous, active low) clears histogram valid bits, counters, FSM.
// ----------------------------------------------------------------------------
module huffman_compressed_size #(
    parameter int ALPHABET = 256,
    parameter int TEXT_MAX = 1024
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire  [hcs_pkg::BYTE_W-1:0]  i_text_byte,
    input  wire                         i_last_byte,
    output logic                        o_strobe,
    output logic [hcs_pkg::OUT_W-1:0]   o_original_bits,
    output logic [hcs_pkg::OUT_W-1:0]   o_compressed_bits,
    output logic                        o_overflow
);

    localparam int AW = $clog2(ALPHABET);      // memory address width
    localparam int KW = $clog2(ALPHABET + 1);  // scan index, holds ALPHABET
    localparam int CW = $clog2(TEXT_MAX + 1);  // counts and merged weights

    // sequencer
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;  // fetch count of the byte
    localparam logic [2:0] S_WRITE = 3'd2;  // store count + 1
    localparam logic [2:0] S_SCAN  = 3'd3;  // find two smallest weights
    localparam logic [2:0] S_MERGE = 3'd4;  // combine them
    localparam logic [2:0] S_DONE  = 3'd5;  // emit the result

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_addr,  n_addr;
    logic          r_last,  n_last;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf,   n_ovf;
    logic [hcs_pkg::OUT_W-1:0] r_total, n_total;

    // scan unit: one compare pair per cycle over the memory
    logic [KW-1:0] r_k,    n_k;
    logic          r_pv,   n_pv;
    logic [AW-1:0] r_pidx, n_pidx;
    logic [CW-1:0] r_m1,   n_m1;
    logic [CW-1:0] r_m2,   n_m2;
    logic [AW-1:0] r_i1,   n_i1;
    logic [AW-1:0] r_i2,   n_i2;
    logic [1:0]    r_cnt,  n_cnt;

    // memory hookup
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] wr_data;
    logic          kill_en;
    logic          clr_all;
    logic [CW-1:0] pair_sum;
    logic          in_alpha;

    hcs_hist #(
        .ALPHABET (ALPHABET),
        .CW       (CW)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_kill_en   (kill_en),
        .i_kill_addr (r_i2),
        .i_clr_all   (clr_all)
    );

    assign busy     = (r_state != S_IDLE);
    assign pair_sum = r_m1 + r_m2;
    // values at or above the alphabet size are ignored
    assign in_alpha = ({1'b0, i_text_byte} < (hcs_pkg::BYTE_W + 1)'(ALPHABET));

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_last  = r_last;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_total = r_total;
        n_k     = r_k;
        n_pv    = r_pv;
        n_pidx  = r_pidx;
        n_m1    = r_m1;
        n_m2    = r_m2;
        n_i1    = r_i1;
        n_i2    = r_i2;
        n_cnt   = r_cnt;
        rd_addr = r_k[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = rd_data + CW'(1);
        kill_en = 1'b0;
        clr_all = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_addr = i_text_byte[AW-1:0];
                    n_last = i_last_byte;
                    n_k    = '0;
                    n_pv   = 1'b0;
                    n_cnt  = hcs_pkg::CAND_NONE;
                    if (in_alpha && (r_count < CW'(TEXT_MAX))) begin
                        n_state = S_READ;
                    end else begin
                        if (in_alpha) begin
                            n_ovf = 1'b1;  // text too long: drop and flag
                        end
                        n_state = i_last_byte ? S_SCAN : S_IDLE;
                    end
                end
            end
            S_READ: begin
                rd_addr = r_addr;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                wr_en   = 1'b1;
                n_count = r_count + CW'(1);
                n_state = r_last ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                n_pv   = (r_k < KW'(ALPHABET));
                n_pidx = r_k[AW-1:0];
                if (r_k < KW'(ALPHABET)) begin
                    n_k = r_k + KW'(1);
                end
                // zero weight means empty slot
                if (r_pv && (rd_data != '0)) begin
                    if ((r_cnt == hcs_pkg::CAND_NONE) || (rd_data < r_m1)) begin
                        n_m2 = r_m1;
                        n_i2 = r_i1;
                        n_m1 = rd_data;
                        n_i1 = r_pidx;
                    end else if ((r_cnt == hcs_pkg::CAND_ONE) || (rd_data < r_m2)) begin
                        n_m2 = rd_data;
                        n_i2 = r_pidx;
                    end
                    if (r_cnt != hcs_pkg::CAND_TWO) begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                if (!r_pv && (r_k == KW'(ALPHABET))) begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (r_cnt == hcs_pkg::CAND_TWO) begin
                    // merged weight replaces the smaller node, the other drops
                    wr_en   = 1'b1;
                    wr_addr = r_i1;
                    wr_data = pair_sum;
                    kill_en = 1'b1;
                    n_total = r_total + hcs_pkg::OUT_W'(pair_sum);
                    n_k     = '0;
                    n_pv    = 1'b0;
                    n_cnt   = hcs_pkg::CAND_NONE;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                clr_all = 1'b1;
                n_count = '0;
                n_ovf   = 1'b0;
                n_total = '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_total  <= '0;
            r_pv     <= 1'b0;
            r_k      <= '0;
            r_cnt    <= hcs_pkg::CAND_NONE;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_total  <= n_total;
            r_pv     <= n_pv;
            r_k      <= n_k;
            r_cnt    <= n_cnt;
            o_strobe <= (r_state == S_DONE);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_last <= n_last;
        r_pidx <= n_pidx;
        r_m1   <= n_m1;
        r_m2   <= n_m2;
        r_i1   <= n_i1;
        r_i2   <= n_i2;
        if (r_state == S_DONE) begin
            o_original_bits   <= hcs_pkg::OUT_W'({r_count, {hcs_pkg::BIT_SHFT{1'b0}}});
            o_compressed_bits <= r_total;
            o_overflow        <= r_ovf;
        end
    end

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire
